[design/lfpd_pkg.sv]
package lfpd_pkg;

   // Sizes of the sample and integral datapaths.
   localparam int SAMPLE_BITS = 10;
   localparam int SUM_BITS    = 32;

   // Fixed field widths.
   localparam int THRESH_BITS = 10;
   localparam int GAIN_BITS   = 16;
   localparam int ERR_BITS    = 3;
   localparam int DELTA_BITS  = ERR_BITS + 1;
   localparam int SPEED_BITS  = 8;
   localparam int DIR_BITS    = 10;
   localparam int MAG_BITS    = DIR_BITS - 1;

   // Samples and the threshold are compared at the wider of their two widths.
   localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

   // Product and sum widths follow from the operand widths.
   localparam int PROD_P_BITS = GAIN_BITS + ERR_BITS;
   localparam int PROD_I_BITS = GAIN_BITS + SUM_BITS;
   localparam int PROD_D_BITS = GAIN_BITS + DELTA_BITS;
   localparam int MIX_BITS    = PROD_I_BITS + 1;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLACK_THRESH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_P       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_I       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_D       = 3'd3;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd512;

   // Drive mapping constants.
   localparam logic [SPEED_BITS-1:0] FULL_SPEED = 8'd255;
   localparam logic signed [DIR_BITS-1:0] DIR_LIMIT     = 10'sd510;
   localparam logic signed [DIR_BITS-1:0] DIR_LIMIT_NEG = -10'sd510;

   typedef logic signed [ERR_BITS-1:0] err_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [THRESH_BITS-1:0]      black_thresh;
      logic signed [GAIN_BITS-1:0] gain_p;
      logic signed [GAIN_BITS-1:0] gain_i;
      logic signed [GAIN_BITS-1:0] gain_d;
   } cfg_type;

   // Result of the error stage for one item.
   typedef struct packed {
      err_type                      err;
      logic signed [SUM_BITS-1:0]   sum;
      logic signed [DELTA_BITS-1:0] delta;
   } front_type;

   // Registered products for one item.
   typedef struct packed {
      err_type                       err;
      logic signed [PROD_P_BITS-1:0] prod_p;
      logic signed [PROD_I_BITS-1:0] prod_i;
      logic signed [PROD_D_BITS-1:0] prod_d;
   } prod_type;

   // Black pattern (far left, left, right, far right) to line position.
   function automatic err_type pos_error(input logic [3:0] pattern);
      err_type e;
      case (pattern)
         4'b0001: e = 3'sd3;
         4'b0010: e = 3'sd1;
         4'b0011: e = 3'sd2;
         4'b0100: e = -3'sd1;
         4'b0111: e = 3'sd3;
         4'b1000: e = -3'sd3;
         4'b1100: e = -3'sd2;
         4'b1110: e = -3'sd3;
         default: e = 3'sd0;
      endcase
      return e;
   endfunction

endpackage

[design/lfpd_front.sv]
module lfpd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [lfpd_pkg::THRESH_BITS-1:0]   black_thresh,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]   far_left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]   left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]   right_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]   far_right_sample,
   output lfpd_pkg::front_type                front
);
   import lfpd_pkg::*;

   logic signed [SUM_BITS-1:0] error_sum_ff, error_sum_in;
   err_type                    last_error_ff, last_error_in;
   logic [CMP_BITS-1:0]        thresh_ext;
   logic [3:0]                 pattern;
   err_type                    err;
   logic signed [SUM_BITS:0]   sum_wide;

   // Threshold each sample and look up the line position.
   always_comb begin
      thresh_ext = CMP_BITS'(black_thresh);
      pattern[3] = CMP_BITS'(far_left_sample)  > thresh_ext;
      pattern[2] = CMP_BITS'(left_sample)      > thresh_ext;
      pattern[1] = CMP_BITS'(right_sample)     > thresh_ext;
      pattern[0] = CMP_BITS'(far_right_sample) > thresh_ext;
      err = pos_error(pattern);
   end

   // Saturating integral and the change of error since the last item.
   always_comb begin
      sum_wide = {error_sum_ff[SUM_BITS-1], error_sum_ff}
               + {{(SUM_BITS-ERR_BITS+1){err[ERR_BITS-1]}}, err};
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         front.sum = {sum_wide[SUM_BITS], {(SUM_BITS-1){~sum_wide[SUM_BITS]}}};
      end else begin
         front.sum = sum_wide[SUM_BITS-1:0];
      end
      front.err   = err;
      front.delta = {err[ERR_BITS-1], err} - {last_error_ff[ERR_BITS-1], last_error_ff};
      error_sum_in  = accept ? front.sum : error_sum_ff;
      last_error_in = accept ? err : last_error_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
      end
   end

endmodule

[design/lfpd_mult.sv]
module lfpd_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  lfpd_pkg::front_type  front,
   input  lfpd_pkg::cfg_type    cfg,
   input  logic                 next_ready,
   output logic                 ready,
   output logic                 prod_valid,
   output lfpd_pkg::prod_type   prod
);
   import lfpd_pkg::*;

   logic     valid_ff, valid_in;
   prod_type prod_ff, prod_in;
   logic signed [PROD_P_BITS-1:0] gp_ext, ep_ext;
   logic signed [PROD_I_BITS-1:0] gi_ext, si_ext;
   logic signed [PROD_D_BITS-1:0] gd_ext, dd_ext;

   // The stage can load when empty or when its item moves on.
   assign ready = !valid_ff || next_ready;

   // Three gain products, operands sign-extended to the product width.
   always_comb begin
      gp_ext = {{(PROD_P_BITS-GAIN_BITS){cfg.gain_p[GAIN_BITS-1]}}, cfg.gain_p};
      ep_ext = {{(PROD_P_BITS-ERR_BITS){front.err[ERR_BITS-1]}}, front.err};
      gi_ext = {{(PROD_I_BITS-GAIN_BITS){cfg.gain_i[GAIN_BITS-1]}}, cfg.gain_i};
      si_ext = {{(PROD_I_BITS-SUM_BITS){front.sum[SUM_BITS-1]}}, front.sum};
      gd_ext = {{(PROD_D_BITS-GAIN_BITS){cfg.gain_d[GAIN_BITS-1]}}, cfg.gain_d};
      dd_ext = {{(PROD_D_BITS-DELTA_BITS){front.delta[DELTA_BITS-1]}}, front.delta};
      prod_in.err    = front.err;
      prod_in.prod_p = gp_ext * ep_ext;
      prod_in.prod_i = gi_ext * si_ext;
      prod_in.prod_d = gd_ext * dd_ext;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (next_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

[design/lfpd_mix.sv]
module lfpd_mix (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              prod_valid,
   input  lfpd_pkg::prod_type                prod,
   output logic                              ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lfpd_pkg::SPEED_BITS-1:0]   rsp_left_speed,
   output logic                              rsp_left_reverse,
   output logic [lfpd_pkg::SPEED_BITS-1:0]   rsp_right_speed,
   output logic                              rsp_right_reverse,
   output logic signed [lfpd_pkg::ERR_BITS-1:0] rsp_position_error
);
   import lfpd_pkg::*;

   logic                       valid_ff, valid_in;
   logic                       load;
   logic signed [MIX_BITS-1:0] mix;
   logic signed [DIR_BITS-1:0] dir;
   logic [MAG_BITS-1:0]        mag;
   logic [SPEED_BITS-1:0]      slow_speed;
   logic                       slow_rev;
   logic [SPEED_BITS-1:0]      left_speed_ff, left_speed_in;
   logic [SPEED_BITS-1:0]      right_speed_ff, right_speed_in;
   logic                       left_rev_ff, left_rev_in;
   logic                       right_rev_ff, right_rev_in;
   err_type                    err_ff;

   assign ready = !valid_ff || !rsp_stall;
   assign load  = prod_valid && ready;

   // Sum the three terms and clamp the direction.
   always_comb begin
      mix = {{(MIX_BITS-PROD_P_BITS){prod.prod_p[PROD_P_BITS-1]}}, prod.prod_p}
          + {{(MIX_BITS-PROD_I_BITS){prod.prod_i[PROD_I_BITS-1]}}, prod.prod_i}
          + {{(MIX_BITS-PROD_D_BITS){prod.prod_d[PROD_D_BITS-1]}}, prod.prod_d};
      if (mix > MIX_BITS'(DIR_LIMIT)) begin
         dir = DIR_LIMIT;
      end else if (mix < MIX_BITS'(DIR_LIMIT_NEG)) begin
         dir = DIR_LIMIT_NEG;
      end else begin
         dir = mix[DIR_BITS-1:0];
      end
   end

   // Map the direction onto the two wheels; the inner wheel slows or reverses.
   always_comb begin
      mag = dir[DIR_BITS-1] ? MAG_BITS'(-dir) : MAG_BITS'(dir);
      if (mag > MAG_BITS'(FULL_SPEED)) begin
         slow_speed = SPEED_BITS'(mag - MAG_BITS'(FULL_SPEED));
         slow_rev   = 1'b1;
      end else begin
         slow_speed = FULL_SPEED - SPEED_BITS'(mag);
         slow_rev   = 1'b0;
      end
      left_speed_in  = FULL_SPEED;
      left_rev_in    = 1'b0;
      right_speed_in = FULL_SPEED;
      right_rev_in   = 1'b0;
      if (dir > 0) begin
         right_speed_in = slow_speed;
         right_rev_in   = slow_rev;
      end else if (dir < 0) begin
         left_speed_in = slow_speed;
         left_rev_in   = slow_rev;
      end
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result register; holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (load) begin
         left_speed_ff  <= left_speed_in;
         left_rev_ff    <= left_rev_in;
         right_speed_ff <= right_speed_in;
         right_rev_ff   <= right_rev_in;
         err_ff         <= prod.err;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_left_speed     = left_speed_ff;
   assign rsp_left_reverse   = left_rev_ff;
   assign rsp_right_speed    = right_speed_ff;
   assign rsp_right_reverse  = right_rev_ff;
   assign rsp_position_error = err_ff;

endmodule

[design/line_follow_pid_drive_core.sv]
// Line-following PID controller with differential wheel drive.
// Input channel (req_): four reflectance samples per item, handshake by
// req_valid and req_stall. Result channel (rsp_): wheel speeds, reverse
// flags and the table position error, handshake by rsp_valid and rsp_stall.
// Configuration (csr_): threshold and the three gains, written by index while
// the block is idle (a rule for the user; the block does not enforce it);
// indices beyond the last register are ignored. Items pass the product
// register, then the result register, which drives rsp_. Throughput: one
// item per cycle while rsp_stall is low, set by the integral update at the
// input, which feeds the next item. The products are registered in a
// middle stage; sum, clamp and drive mapping fill the result register.
// When the receiver stalls, the result register holds its item, the product
// stage takes one more item only if empty, and then req_stall is raised.
// Reset clears the integral, the previous error, the gains and all items in
// flight, and sets the threshold to 512.
module line_follow_pid_drive_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_far_left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_right_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_far_right_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [lfpd_pkg::SPEED_BITS-1:0]       rsp_left_speed,
   output logic                                  rsp_left_reverse,
   output logic [lfpd_pkg::SPEED_BITS-1:0]       rsp_right_speed,
   output logic                                  rsp_right_reverse,
   output logic signed [lfpd_pkg::ERR_BITS-1:0]  rsp_position_error,
   input  logic                                  csr_write,
   input  logic [lfpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import lfpd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   front_type front;
   prod_type  prod;
   logic      accept;
   logic      mult_ready;
   logic      mix_ready;
   logic      prod_valid;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BLACK_THRESH: cfg_in.black_thresh = csr_wdata[THRESH_BITS-1:0];
            CSR_GAIN_P:       cfg_in.gain_p       = csr_wdata[GAIN_BITS-1:0];
            CSR_GAIN_I:       cfg_in.gain_i       = csr_wdata[GAIN_BITS-1:0];
            CSR_GAIN_D:       cfg_in.gain_d       = csr_wdata[GAIN_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_thresh <= THRESH_RESET;
         cfg_ff.gain_p       <= '0;
         cfg_ff.gain_i       <= '0;
         cfg_ff.gain_d       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // An item enters when the product stage can take it.
   assign req_stall = !mult_ready;
   assign accept    = req_valid && mult_ready;

   lfpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .black_thresh     (cfg_ff.black_thresh),
      .far_left_sample  (req_far_left_sample),
      .left_sample      (req_left_sample),
      .right_sample     (req_right_sample),
      .far_right_sample (req_far_right_sample),
      .front            (front)
   );

   lfpd_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .front      (front),
      .cfg        (cfg_ff),
      .next_ready (mix_ready),
      .ready      (mult_ready),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   lfpd_mix u_mix (
      .clock              (clock),
      .reset              (reset),
      .prod_valid         (prod_valid),
      .prod               (prod),
      .ready              (mix_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_left_reverse   (rsp_left_reverse),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_right_reverse  (rsp_right_reverse),
      .rsp_position_error (rsp_position_error)
   );

endmodule

[tb/drive_command_checker.sv]
module drive_command_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_far_left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_left_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_right_sample,
   input  logic [lfpd_pkg::SAMPLE_BITS-1:0]      req_far_right_sample,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [lfpd_pkg::SPEED_BITS-1:0]       rsp_left_speed,
   input  logic                                  rsp_left_reverse,
   input  logic [lfpd_pkg::SPEED_BITS-1:0]       rsp_right_speed,
   input  logic                                  rsp_right_reverse,
   input  logic signed [lfpd_pkg::ERR_BITS-1:0]  rsp_position_error,
   input  logic                                  csr_write,
   input  logic [lfpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                    error_count,
   output int                                    pending_count
);

   import lfpd_pkg::*;

   // One wheel command as the block should return it.
   typedef struct packed {
      logic [SPEED_BITS-1:0] left_speed;
      logic                  left_reverse;
      logic [SPEED_BITS-1:0] right_speed;
      logic                  right_reverse;
      err_type               position_error;
   } wheel_cmd_type;

   localparam longint INTEGRAL_MAX = (longint'(1) <<< (SUM_BITS - 1)) - 1;
   localparam longint INTEGRAL_MIN = -INTEGRAL_MAX - 1;

   // Shadow copy of the registers and of the controller state.
   logic [THRESH_BITS-1:0]      black_level;
   logic signed [GAIN_BITS-1:0] kp;
   logic signed [GAIN_BITS-1:0] ki;
   logic signed [GAIN_BITS-1:0] kd;
   longint                      error_integral;
   int                          prev_offset;
   int                          mismatches;
   wheel_cmd_type               expected_wheels[$];

   // Line offset for the black pattern (far left, left, right, far right).
   function automatic int line_offset(input logic [3:0] black);
      case (black)
         4'b1000, 4'b1110: line_offset = -3;
         4'b1100:          line_offset = -2;
         4'b0100:          line_offset = -1;
         4'b0010:          line_offset = 1;
         4'b0011:          line_offset = 2;
         4'b0001, 4'b0111: line_offset = 3;
         default:          line_offset = 0;
      endcase
   endfunction

   // Works out the wheel command for one item and advances the PID state.
   function automatic wheel_cmd_type predict_wheels(input logic [SAMPLE_BITS-1:0] fl,
                                                    input logic [SAMPLE_BITS-1:0] l,
                                                    input logic [SAMPLE_BITS-1:0] r,
                                                    input logic [SAMPLE_BITS-1:0] fr);
      logic [3:0]            black;
      int                    offset;
      longint                steer;
      longint                mag;
      logic [SPEED_BITS-1:0] slow_speed;
      logic                  slow_reverse;
      wheel_cmd_type         cmd;
      black = {fl > black_level, l > black_level, r > black_level, fr > black_level};
      offset = line_offset(black);

      // The integral saturates at the signed limits of its width.
      error_integral = error_integral + offset;
      if (error_integral > INTEGRAL_MAX) error_integral = INTEGRAL_MAX;
      if (error_integral < INTEGRAL_MIN) error_integral = INTEGRAL_MIN;

      steer = longint'(kp) * offset + longint'(ki) * error_integral +
              longint'(kd) * (offset - prev_offset);
      prev_offset = offset;
      if (steer > longint'(DIR_LIMIT)) steer = longint'(DIR_LIMIT);
      if (steer < longint'(DIR_LIMIT_NEG)) steer = longint'(DIR_LIMIT_NEG);

      // The inner wheel slows down, and past full speed it runs backward.
      mag = (steer < 0) ? -steer : steer;
      if (mag > longint'(FULL_SPEED)) begin
         slow_speed   = SPEED_BITS'(mag - longint'(FULL_SPEED));
         slow_reverse = 1'b1;
      end else begin
         slow_speed   = SPEED_BITS'(longint'(FULL_SPEED) - mag);
         slow_reverse = 1'b0;
      end
      cmd.left_speed     = FULL_SPEED;
      cmd.left_reverse   = 1'b0;
      cmd.right_speed    = FULL_SPEED;
      cmd.right_reverse  = 1'b0;
      cmd.position_error = err_type'(offset);
      if (steer > 0) begin
         cmd.right_speed   = slow_speed;
         cmd.right_reverse = slow_reverse;
      end else if (steer < 0) begin
         cmd.left_speed   = slow_speed;
         cmd.left_reverse = slow_reverse;
      end
      return cmd;
   endfunction

   // Track register writes, predict each accepted item and check each result.
   always @(posedge clock) begin : watch
      wheel_cmd_type want;
      if (reset) begin
         black_level    = THRESH_RESET;
         kp             = '0;
         ki             = '0;
         kd             = '0;
         error_integral = 0;
         prev_offset    = 0;
         mismatches     = 0;
         expected_wheels.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BLACK_THRESH: black_level = csr_wdata[THRESH_BITS-1:0];
               CSR_GAIN_P:       kp = csr_wdata;
               CSR_GAIN_I:       ki = csr_wdata;
               CSR_GAIN_D:       kd = csr_wdata;
               default: ;
            endcase
         end

         // Results are taken first so that a spurious one never meets a fresh item.
         if (rsp_valid && !rsp_stall) begin
            if (expected_wheels.size() == 0) begin
               $error("wheel command returned with no item outstanding");
               mismatches++;
            end else begin
               want = expected_wheels.pop_front();
               if (rsp_left_speed != want.left_speed) begin
                  $error("left_speed: expected %0d, got %0d", want.left_speed,
                         rsp_left_speed);
                  mismatches++;
               end
               if (rsp_left_reverse != want.left_reverse) begin
                  $error("left_reverse: expected %0d, got %0d", want.left_reverse,
                         rsp_left_reverse);
                  mismatches++;
               end
               if (rsp_right_speed != want.right_speed) begin
                  $error("right_speed: expected %0d, got %0d", want.right_speed,
                         rsp_right_speed);
                  mismatches++;
               end
               if (rsp_right_reverse != want.right_reverse) begin
                  $error("right_reverse: expected %0d, got %0d", want.right_reverse,
                         rsp_right_reverse);
                  mismatches++;
               end
               if (rsp_position_error != want.position_error) begin
                  $error("position_error: expected %0d, got %0d", want.position_error,
                         rsp_position_error);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            expected_wheels.push_back(predict_wheels(req_far_left_sample, req_left_sample,
                                                     req_right_sample,
                                                     req_far_right_sample));
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_wheels.size();
   end

endmodule

[tb/tb.sv]
module tb;

   import lfpd_pkg::*;

   localparam int RUN_LIMIT   = 200000;
   localparam int LONG_HOLD   = 40;
   localparam int PHASE_ITEMS = 60;
   localparam int PHASES      = 8;
   localparam int SETTLE      = 8;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [SAMPLE_BITS-1:0]        req_far_left_sample = '0;
   logic [SAMPLE_BITS-1:0]        req_left_sample = '0;
   logic [SAMPLE_BITS-1:0]        req_right_sample = '0;
   logic [SAMPLE_BITS-1:0]        req_far_right_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [SPEED_BITS-1:0]         rsp_left_speed;
   logic                          rsp_left_reverse;
   logic [SPEED_BITS-1:0]         rsp_right_speed;
   logic                          rsp_right_reverse;
   logic signed [ERR_BITS-1:0]    rsp_position_error;
   logic                          csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   int                            error_count;
   int                            pending_count;
   int                            cycle_count = 0;

   // Traffic shaping for the sender and the receiver.
   int                            send_idle_pct = 0;
   int                            recv_stall_pct = 0;
   int                            hold_requests = 0;
   int                            holds_served = 0;
   int                            hold_left = 0;
   logic [THRESH_BITS-1:0]        line_thr = THRESH_RESET;

   line_follow_pid_drive_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_far_left_sample  (req_far_left_sample),
      .req_left_sample      (req_left_sample),
      .req_right_sample     (req_right_sample),
      .req_far_right_sample (req_far_right_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_left_reverse     (rsp_left_reverse),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_right_reverse    (rsp_right_reverse),
      .rsp_position_error   (rsp_position_error),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   drive_command_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_far_left_sample  (req_far_left_sample),
      .req_left_sample      (req_left_sample),
      .req_right_sample     (req_right_sample),
      .req_far_right_sample (req_far_right_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_left_reverse     (rsp_left_reverse),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_right_reverse    (rsp_right_reverse),
      .rsp_position_error   (rsp_position_error),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .error_count          (error_count),
      .pending_count        (pending_count)
   );

   always #2 clock = ~clock;

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left = LONG_HOLD;
         holds_served = holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Selects how often each side idles: none, sender, receiver or both.
   task automatic set_traffic(input int mode);
      case (mode)
         1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
         3:       begin send_idle_pct = 25; recv_stall_pct = 25; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Offers one item and returns at the edge that accepts it.
   task automatic send_samples(input logic [SAMPLE_BITS-1:0] fl,
                               input logic [SAMPLE_BITS-1:0] l,
                               input logic [SAMPLE_BITS-1:0] r,
                               input logic [SAMPLE_BITS-1:0] fr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_far_left_sample  <= fl;
      req_left_sample      <= l;
      req_right_sample     <= r;
      req_far_right_sample <= fr;
      // The stall is settled by the falling edge, so the next rising edge decides.
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Writes every register, then an unused index that must be ignored.
   task automatic write_regs(input logic [THRESH_BITS-1:0] thr,
                             input logic [GAIN_BITS-1:0]   gp,
                             input logic [GAIN_BITS-1:0]   gi,
                             input logic [GAIN_BITS-1:0]   gd);
      logic [CSR_DATA_BITS-1:0] raw;
      raw = CSR_DATA_BITS'($urandom);
      raw[THRESH_BITS-1:0] = thr;
      csr_write <= 1'b1;
      csr_index <= CSR_BLACK_THRESH;
      csr_wdata <= raw;
      @(posedge clock);
      csr_index <= CSR_GAIN_P;
      csr_wdata <= gp;
      @(posedge clock);
      csr_index <= CSR_GAIN_I;
      csr_wdata <= gi;
      @(posedge clock);
      csr_index <= CSR_GAIN_D;
      csr_wdata <= gd;
      @(posedge clock);
      csr_index <= CSR_GAIN_D + CSR_INDEX_BITS'($urandom_range(1, 4));
      csr_wdata <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
      line_thr = thr;
   endtask

   // Stops offering items and waits until every result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Picks a sample that reads black or white under the current threshold.
   function automatic logic [SAMPLE_BITS-1:0] sensor_level(input logic black);
      if ($urandom_range(0, 4) == 0) begin
         if (black && line_thr != SAMPLE_MAX) return line_thr + 1'b1;
         return black ? SAMPLE_MAX : line_thr;
      end
      if (black && line_thr != SAMPLE_MAX)
         return SAMPLE_BITS'($urandom_range(int'(line_thr) + 1, int'(SAMPLE_MAX)));
      if (black) return SAMPLE_MAX;
      return SAMPLE_BITS'($urandom_range(0, int'(line_thr)));
   endfunction

   // Mostly a chosen black pattern with random levels, sometimes raw noise.
   task automatic send_random_item();
      logic [3:0] pat;
      if ($urandom_range(0, 99) < 15) begin
         send_samples(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                      SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
      end else begin
         pat = 4'($urandom);
         send_samples(sensor_level(pat[3]), sensor_level(pat[2]),
                      sensor_level(pat[1]), sensor_level(pat[0]));
      end
   endtask

   initial begin : stimulus
      logic [THRESH_BITS-1:0] thr;
      logic [GAIN_BITS-1:0]   gp;
      logic [GAIN_BITS-1:0]   gi;
      logic [GAIN_BITS-1:0]   gd;
      logic [SAMPLE_BITS-1:0] hi;
      logic [SAMPLE_BITS-1:0] lo;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the default threshold sits between 512 and 513.
      set_traffic(0);
      send_samples('0, '0, '0, '0);
      send_samples(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_samples(10'd513, '0, '0, '0);
      send_samples(10'd512, '0, '0, SAMPLE_MAX);
      wait_for_results();

      // Every black pattern, with levels on both sides of the threshold.
      write_regs(10'd300, 16'd70, 16'd2, 16'd45);
      for (int pat = 0; pat < 16; pat++) begin
         hi = pat[0] ? SAMPLE_MAX : line_thr + 1'b1;
         lo = pat[0] ? '0 : line_thr;
         send_samples(pat[3] ? hi : lo, pat[2] ? hi : lo, pat[1] ? hi : lo,
                      pat[0] ? hi : lo);
      end
      wait_for_results();

      // Random phases, each with its own settings and traffic pattern.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               thr = '0;
               gp = 16'h7FFF; gi = 16'h8000; gd = 16'h7FFF;
            end
            1: begin
               thr = SAMPLE_MAX;
               gp = GAIN_BITS'($urandom); gi = GAIN_BITS'($urandom);
               gd = GAIN_BITS'($urandom);
            end
            2: begin
               thr = THRESH_RESET;
               gp = 16'h8000; gi = 16'h7FFF; gd = 16'h8000;
            end
            5: begin
               thr = THRESH_BITS'($urandom);
               gp = GAIN_BITS'($urandom); gi = GAIN_BITS'($urandom);
               gd = GAIN_BITS'($urandom);
            end
            default: begin
               // Modest gains keep the steering inside the clamp most of the time.
               thr = THRESH_BITS'($urandom_range(100, 900));
               gp = GAIN_BITS'($urandom_range(0, 300)) - 16'd150;
               gi = GAIN_BITS'($urandom_range(0, 6)) - 16'd3;
               gd = GAIN_BITS'($urandom_range(0, 240)) - 16'd120;
            end
         endcase
         write_regs(thr, gp, gi, gd);
         set_traffic(ph % 4);
         // One phase holds the receiver off long enough to back the block up.
         if (ph == 4) hold_requests = hold_requests + 1;
         repeat (PHASE_ITEMS) send_random_item();
         wait_for_results();
      end

      repeat (SETTLE) @(negedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
design/lfpd_pkg.sv
design/lfpd_front.sv
design/lfpd_mult.sv
design/lfpd_mix.sv
design/line_follow_pid_drive_core.sv
tb/drive_command_checker.sv
tb/tb.sv
